@@ rtl/core/rtoe_pkg.sv @@
// Shared types and constants of the retransmission timeout estimator.
package rtoe_pkg;

	typedef logic [1:0]  action_t;
	typedef logic [1:0]  cfg_index_t;
	typedef logic [15:0] cfg_data_t;
	typedef logic [15:0] ms16_t;
	typedef logic [7:0]  count_t;
	typedef logic [30:0] rtt_t;
	typedef logic [31:0] est_t;

	localparam action_t ACT_INIT    = 2'd0;
	localparam action_t ACT_SAMPLE  = 2'd1;
	localparam action_t ACT_TIMEOUT = 2'd2;

	localparam cfg_index_t REG_RETRY_LIMIT   = 2'd0;
	localparam cfg_index_t REG_MIN_TIMEOUT   = 2'd1;
	localparam cfg_index_t REG_MAX_TIMEOUT   = 2'd2;
	localparam cfg_index_t REG_HANDSHAKE_CAP = 2'd3;

	localparam count_t RETRY_LIMIT_RST   = 8'd15;
	localparam ms16_t  MIN_TIMEOUT_RST   = 16'd1000;
	localparam ms16_t  MAX_TIMEOUT_RST   = 16'd60000;
	localparam ms16_t  HANDSHAKE_CAP_RST = 16'd3000;
	localparam count_t RETRY_SAT         = 8'd255;

endpackage

@@ rtl/core/rtoe_if.sv @@
// Request, response and configuration channel interfaces of the estimator.
interface rtoe_req_if;
	logic                 valid;
	logic                 ready;
	rtoe_pkg::action_t    action;
	rtoe_pkg::rtt_t       rtt_sample;
	logic                 in_handshake;
	modport source (output valid, action, rtt_sample, in_handshake, input ready);
	modport sink (input valid, action, rtt_sample, in_handshake, output ready);
endinterface

interface rtoe_rsp_if;
	logic                 valid;
	logic                 ready;
	rtoe_pkg::ms16_t      timeout_ms;
	logic                 give_up;
	rtoe_pkg::count_t     retry_count;
	modport source (output valid, timeout_ms, give_up, retry_count, input ready);
	modport sink (input valid, timeout_ms, give_up, retry_count, output ready);
endinterface

interface rtoe_cfg_if;
	logic                 valid;
	logic                 ready;
	rtoe_pkg::cfg_index_t index;
	rtoe_pkg::cfg_data_t  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/retransmission_timeout_estimator_core.sv @@
// Retransmission timeout estimator: input register, one-pass update, result register.
//
//   channel  dir  payload                                  handshake
//   req      in   action, rtt_sample, in_handshake         valid / ready
//   rsp      out  timeout_ms, give_up, retry_count         valid / ready
//   cfg      in   index, data                              valid / ready (always ready)
//
// A response becomes valid once its accepted request has passed from the input register
// through the estimate update into the result register.
// One request per cycle is sustained while responses are taken; the estimate registers
// update as a request moves into the result register, so the next request sees them at once.
// A stalled response holds the input register, which then drops ready.
// arst_n clears valid flags, estimate and retry count and loads register defaults.
module retransmission_timeout_estimator_core (
	input logic clk,
	input logic arst_n,
	rtoe_req_if.sink req,
	rtoe_rsp_if.source rsp,
	rtoe_cfg_if.sink cfg
);

	logic                 valid_s1;
	rtoe_pkg::action_t    action_s1;
	rtoe_pkg::rtt_t       rtt_s1;
	logic                 hs_s1;

	rtoe_pkg::count_t     retry_limit_q;
	rtoe_pkg::ms16_t      min_timeout_q;
	rtoe_pkg::ms16_t      max_timeout_q;
	rtoe_pkg::ms16_t      handshake_cap_q;

	rtoe_pkg::est_t       srtt_q;
	rtoe_pkg::est_t       var_q;
	rtoe_pkg::ms16_t      timeout_q;
	rtoe_pkg::count_t     retries_q;

	logic                 out_valid_q;
	rtoe_pkg::ms16_t      out_timeout_q;
	logic                 out_give_up_q;
	rtoe_pkg::count_t     out_retries_q;

	logic                 advance;

	rtoe_pkg::est_t       srtt_d;
	rtoe_pkg::est_t       var_d;
	rtoe_pkg::ms16_t      timeout_d;
	rtoe_pkg::count_t     retries_d;
	logic                 give_up_d;

	logic [32:0]          r_ext;
	logic [32:0]          diff;
	logic [34:0]          var_sum;
	logic [34:0]          srtt_sum;
	logic [33:0]          var4;
	logic [33:0]          term;
	logic [34:0]          est_total;
	logic [16:0]          doubled;
	rtoe_pkg::ms16_t      backoff;
	rtoe_pkg::count_t     retries_inc;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_valid_q;
	assign rsp.timeout_ms  = out_timeout_q;
	assign rsp.give_up     = out_give_up_q;
	assign rsp.retry_count = out_retries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q   <= rtoe_pkg::RETRY_LIMIT_RST;
			min_timeout_q   <= rtoe_pkg::MIN_TIMEOUT_RST;
			max_timeout_q   <= rtoe_pkg::MAX_TIMEOUT_RST;
			handshake_cap_q <= rtoe_pkg::HANDSHAKE_CAP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rtoe_pkg::REG_RETRY_LIMIT:   retry_limit_q   <= cfg.data[7:0];
				rtoe_pkg::REG_MIN_TIMEOUT:   min_timeout_q   <= cfg.data;
				rtoe_pkg::REG_MAX_TIMEOUT:   max_timeout_q   <= cfg.data;
				rtoe_pkg::REG_HANDSHAKE_CAP: handshake_cap_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			rtt_s1    <= req.rtt_sample;
			hs_s1     <= req.in_handshake;
		end
	end

	// estimate update
	always_comb begin
		r_ext       = {2'b00, rtt_s1};
		diff        = ({1'b0, srtt_q} > r_ext) ? ({1'b0, srtt_q} - r_ext)
			: (r_ext - {1'b0, srtt_q});
		var_sum     = {3'b000, var_q} + {2'b00, var_q, 1'b0} + {2'b00, diff};
		srtt_sum    = {srtt_q, 3'b000} - {3'b000, srtt_q} + {2'b00, r_ext};
		retries_inc = (retries_q == rtoe_pkg::RETRY_SAT) ? retries_q : retries_q + 8'd1;
		doubled     = {timeout_q, 1'b0};
		backoff     = (doubled > {1'b0, max_timeout_q}) ? max_timeout_q : doubled[15:0];
		if (hs_s1 && backoff > handshake_cap_q) begin
			backoff = handshake_cap_q;
		end

		srtt_d    = srtt_q;
		var_d     = var_q;
		timeout_d = timeout_q;
		retries_d = retries_q;
		give_up_d = 1'b0;

		case (action_s1)
			rtoe_pkg::ACT_INIT: begin
				srtt_d    = '0;
				var_d     = '0;
				retries_d = '0;
				timeout_d = min_timeout_q;
			end
			rtoe_pkg::ACT_SAMPLE: begin
				if (rtt_s1 == '0) begin
					if (var_q == '0) begin
						timeout_d = min_timeout_q;
					end
				end else if (var_q == '0) begin
					srtt_d = {1'b0, rtt_s1};
					var_d  = {2'b00, rtt_s1[30:1]};
				end else begin
					var_d  = var_sum[33:2];
					srtt_d = srtt_sum[34:3];
				end
			end
			rtoe_pkg::ACT_TIMEOUT: begin
				retries_d = retries_inc;
				if (retries_inc < retry_limit_q) begin
					timeout_d = backoff;
				end else begin
					give_up_d = 1'b1;
				end
			end
			default: ;
		endcase

		var4      = {var_d, 2'b00};
		term      = (var4 > {18'd0, min_timeout_q}) ? var4 : {18'd0, min_timeout_q};
		est_total = {3'b000, srtt_d} + {1'b0, term};
		if (action_s1 == rtoe_pkg::ACT_SAMPLE && rtt_s1 != '0) begin
			timeout_d = (est_total > {19'd0, max_timeout_q}) ? max_timeout_q
				: est_total[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q    <= '0;
			var_q     <= '0;
			timeout_q <= rtoe_pkg::MIN_TIMEOUT_RST;
			retries_q <= '0;
		end else if (advance) begin
			srtt_q    <= srtt_d;
			var_q     <= var_d;
			timeout_q <= timeout_d;
			retries_q <= retries_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_timeout_q <= timeout_d;
			out_give_up_q <= give_up_d;
			out_retries_q <= retries_d;
		end
	end

endmodule
